>>> rtl/dapid_pkg.sv
// Shared types, constants and fixed-point helpers for the dual-axis PID tilt controller.
// Used by every module in rtl/; depends on nothing else.
package dapid_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH + 1;
    localparam int SUM_WIDTH  = DATA_WIDTH + 2;
    localparam int WIDE_WIDTH = DATA_WIDTH + 4;
    localparam int GAIN_WIDTH = 31;
    localparam int TIME_WIDTH = 16;
    localparam int ADDR_WIDTH = 5;
    localparam int APB_WIDTH  = 32;

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [2:0] REG_STEP_TIME   = 3'd3;
    localparam logic [2:0] REG_LOOP_RATE   = 3'd4;
    localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;
    localparam logic [2:0] REG_OUT_LIMIT   = 3'd6;
    localparam logic [2:0] REG_ANGLE_SCALE = 3'd7;

    localparam logic [GAIN_WIDTH-1:0] RST_GAIN_PROP   = 31'd52429;
    localparam logic [GAIN_WIDTH-1:0] RST_GAIN_INTEG  = 31'd13107;
    localparam logic [GAIN_WIDTH-1:0] RST_GAIN_DERIV  = 31'd5898;
    localparam logic [TIME_WIDTH-1:0] RST_STEP_TIME   = 16'd66;
    localparam logic [TIME_WIDTH-1:0] RST_LOOP_RATE   = 16'd1000;
    localparam logic [GAIN_WIDTH-1:0] RST_INTEG_LIMIT = 31'd3276800;
    localparam logic [GAIN_WIDTH-1:0] RST_OUT_LIMIT   = 31'd5472256;
    localparam logic [GAIN_WIDTH-1:0] RST_ANGLE_SCALE = 31'd9811;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] gain_prop;
        logic [GAIN_WIDTH-1:0] gain_integ;
        logic [GAIN_WIDTH-1:0] gain_deriv;
        logic [TIME_WIDTH-1:0] step_time;
        logic [TIME_WIDTH-1:0] loop_rate;
        logic [GAIN_WIDTH-1:0] integ_limit;
        logic [GAIN_WIDTH-1:0] out_limit;
        logic [GAIN_WIDTH-1:0] angle_scale;
    } cfg_t;

    // Datapath operations, one per controller step.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INTEG,
        DP_DIFF,
        DP_PROP,
        DP_ACC,
        DP_DERIV,
        DP_SUM,
        DP_SCALE,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INTEG,
        ST_DIFF,
        ST_PROP,
        ST_ACC,
        ST_DERIV,
        ST_SUM,
        ST_SCALE,
        ST_OUT
    } ctrl_state_t;

    // Saturate a wide signed value to the data width.
    function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [PROD_WIDTH-1:0] v);
        logic [PROD_WIDTH-DATA_WIDTH:0] top;
        top = v[PROD_WIDTH-1:DATA_WIDTH-1];
        if (top == '0 || top == '1)
            return v[DATA_WIDTH-1:0];
        else if (v[PROD_WIDTH-1])
            return DATA_MIN;
        else
            return DATA_MAX;
    endfunction

    // Clamp to +-lim; lim is below 2^31, so the result always fits the data width.
    function automatic logic signed [DATA_WIDTH-1:0] clamp_mag(
        input logic signed [WIDE_WIDTH-1:0] x,
        input logic        [GAIN_WIDTH-1:0] lim
    );
        logic signed [WIDE_WIDTH-1:0] pos;
        logic signed [WIDE_WIDTH-1:0] neg;
        pos = signed'({{(WIDE_WIDTH-GAIN_WIDTH){1'b0}}, lim});
        neg = -pos;
        if (x > pos)
            return pos[DATA_WIDTH-1:0];
        else if (x < neg)
            return neg[DATA_WIDTH-1:0];
        else
            return x[DATA_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/dapid_regs.sv
// APB configuration register file for the PID tilt controller.
// Depends on dapid_pkg for the register indexes, reset values and cfg_t.
module dapid_regs
    import dapid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [APB_WIDTH-1:0]  pwdata,
    output logic [APB_WIDTH-1:0]  prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop   <= RST_GAIN_PROP;
            cfg_reg.gain_integ  <= RST_GAIN_INTEG;
            cfg_reg.gain_deriv  <= RST_GAIN_DERIV;
            cfg_reg.step_time   <= RST_STEP_TIME;
            cfg_reg.loop_rate   <= RST_LOOP_RATE;
            cfg_reg.integ_limit <= RST_INTEG_LIMIT;
            cfg_reg.out_limit   <= RST_OUT_LIMIT;
            cfg_reg.angle_scale <= RST_ANGLE_SCALE;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GAIN_PROP:   cfg_reg.gain_prop   <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_INTEG:  cfg_reg.gain_integ  <= pwdata[GAIN_WIDTH-1:0];
                REG_GAIN_DERIV:  cfg_reg.gain_deriv  <= pwdata[GAIN_WIDTH-1:0];
                REG_STEP_TIME:   cfg_reg.step_time   <= pwdata[TIME_WIDTH-1:0];
                REG_LOOP_RATE:   cfg_reg.loop_rate   <= pwdata[TIME_WIDTH-1:0];
                REG_INTEG_LIMIT: cfg_reg.integ_limit <= pwdata[GAIN_WIDTH-1:0];
                REG_OUT_LIMIT:   cfg_reg.out_limit   <= pwdata[GAIN_WIDTH-1:0];
                REG_ANGLE_SCALE: cfg_reg.angle_scale <= pwdata[GAIN_WIDTH-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_GAIN_PROP:   prdata = {{(APB_WIDTH-GAIN_WIDTH){1'b0}}, cfg_reg.gain_prop};
            REG_GAIN_INTEG:  prdata = {{(APB_WIDTH-GAIN_WIDTH){1'b0}}, cfg_reg.gain_integ};
            REG_GAIN_DERIV:  prdata = {{(APB_WIDTH-GAIN_WIDTH){1'b0}}, cfg_reg.gain_deriv};
            REG_STEP_TIME:   prdata = {{(APB_WIDTH-TIME_WIDTH){1'b0}}, cfg_reg.step_time};
            REG_LOOP_RATE:   prdata = {{(APB_WIDTH-TIME_WIDTH){1'b0}}, cfg_reg.loop_rate};
            REG_INTEG_LIMIT: prdata = {{(APB_WIDTH-GAIN_WIDTH){1'b0}}, cfg_reg.integ_limit};
            REG_OUT_LIMIT:   prdata = {{(APB_WIDTH-GAIN_WIDTH){1'b0}}, cfg_reg.out_limit};
            REG_ANGLE_SCALE: prdata = {{(APB_WIDTH-GAIN_WIDTH){1'b0}}, cfg_reg.angle_scale};
            default:         prdata = '0;
        endcase
    end

endmodule

>>> rtl/dapid_lane.sv
// One PID axis: error, clamped integrator, derivative and tilt scaling on one multiplier.
// Depends on dapid_pkg for the command type, cfg_t and the saturation helpers.
module dapid_lane
    import dapid_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  cfg_t                         cfg,
    input  logic signed [DATA_WIDTH-1:0] meas,
    input  logic signed [DATA_WIDTH-1:0] target,
    output logic signed [DATA_WIDTH-1:0] angle
);

    logic signed [DATA_WIDTH-1:0] err_reg,   err_next;
    logic signed [DATA_WIDTH:0]   diff_reg,  diff_next;
    logic signed [DATA_WIDTH-1:0] prev_reg,  prev_next;
    logic signed [DATA_WIDTH-1:0] acc_reg,   acc_next;
    logic signed [DATA_WIDTH-1:0] deriv_reg, deriv_next;
    logic signed [SUM_WIDTH-1:0]  sum_reg,   sum_next;
    logic signed [PROD_WIDTH-1:0] prod_reg,  prod_next;

    logic signed [DATA_WIDTH:0]   mul_a;
    logic signed [DATA_WIDTH-1:0] mul_b;
    logic signed [PROD_WIDTH-1:0] mul_p;
    logic signed [PROD_WIDTH-1:0] prod_shr;
    logic signed [DATA_WIDTH-1:0] term;

    // The product of the previous step, scaled back to Q16.16 and saturated.
    assign prod_shr = prod_reg >>> FRAC_BITS;
    assign term     = sat_w(prod_shr);
    assign angle    = term;
    assign mul_p    = mul_a * mul_b;

    always_comb
    begin
        err_next   = err_reg;
        diff_next  = diff_reg;
        prev_next  = prev_reg;
        acc_next   = acc_reg;
        deriv_next = deriv_reg;
        sum_next   = sum_reg;
        prod_next  = prod_reg;
        mul_a      = (DATA_WIDTH+1)'(err_reg);
        mul_b      = signed'({{(DATA_WIDTH-TIME_WIDTH){1'b0}}, cfg.step_time});
        case (cmd.op)
            DP_LOAD:
            begin
                err_next = sat_w(PROD_WIDTH'(meas) - PROD_WIDTH'(target));
            end
            DP_INTEG:
            begin
                mul_a     = (DATA_WIDTH+1)'(err_reg);
                mul_b     = signed'({{(DATA_WIDTH-TIME_WIDTH){1'b0}}, cfg.step_time});
                prod_next = mul_p;
                diff_next = (DATA_WIDTH+1)'(err_reg) - (DATA_WIDTH+1)'(prev_reg);
                prev_next = err_reg;
            end
            DP_DIFF:
            begin
                mul_a     = diff_reg;
                mul_b     = signed'({{(DATA_WIDTH-TIME_WIDTH){1'b0}}, cfg.loop_rate});
                prod_next = mul_p;
                // Saturating and then clamping equals clamping alone, the limit being in range.
                acc_next  = clamp_mag(WIDE_WIDTH'(acc_reg) + WIDE_WIDTH'(term), cfg.integ_limit);
            end
            DP_PROP:
            begin
                mul_a      = (DATA_WIDTH+1)'(err_reg);
                mul_b      = signed'({1'b0, cfg.gain_prop});
                prod_next  = mul_p;
                deriv_next = sat_w(prod_reg);
            end
            DP_ACC:
            begin
                mul_a     = (DATA_WIDTH+1)'(acc_reg);
                mul_b     = signed'({1'b0, cfg.gain_integ});
                prod_next = mul_p;
                sum_next  = SUM_WIDTH'(term);
            end
            DP_DERIV:
            begin
                mul_a     = (DATA_WIDTH+1)'(deriv_reg);
                mul_b     = signed'({1'b0, cfg.gain_deriv});
                prod_next = mul_p;
                sum_next  = sum_reg + SUM_WIDTH'(term);
            end
            DP_SUM:
            begin
                sum_next = SUM_WIDTH'(clamp_mag(WIDE_WIDTH'(sum_reg) + WIDE_WIDTH'(term),
                                                cfg.out_limit));
            end
            DP_SCALE:
            begin
                mul_a     = (DATA_WIDTH+1)'(sum_reg);
                mul_b     = signed'({1'b0, cfg.angle_scale});
                prod_next = mul_p;
            end
            DP_NOP, DP_OUT:
            begin
                prod_next = prod_reg;
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            prev_reg <= prev_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        diff_reg  <= diff_next;
        deriv_reg <= deriv_next;
        sum_reg   <= sum_next;
        prod_reg  <= prod_next;
    end

endmodule

>>> rtl/dapid_datapath.sv
// Datapath: the X and Y PID lanes and the registered result.
// Depends on dapid_pkg and dapid_lane.
module dapid_datapath
    import dapid_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  cfg_t                         cfg,
    input  logic signed [DATA_WIDTH-1:0] meas_x,
    input  logic signed [DATA_WIDTH-1:0] meas_y,
    input  logic signed [DATA_WIDTH-1:0] target_x,
    input  logic signed [DATA_WIDTH-1:0] target_y,
    output logic signed [DATA_WIDTH-1:0] tilt_first,
    output logic signed [DATA_WIDTH-1:0] tilt_second
);

    logic signed [DATA_WIDTH-1:0] angle_x;
    logic signed [DATA_WIDTH-1:0] angle_y;
    logic signed [DATA_WIDTH-1:0] neg_x;
    logic signed [DATA_WIDTH-1:0] first_reg;
    logic signed [DATA_WIDTH-1:0] second_reg;

    dapid_lane u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .meas   (meas_x),
        .target (target_x),
        .angle  (angle_x)
    );

    dapid_lane u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg),
        .meas   (meas_y),
        .target (target_y),
        .angle  (angle_y)
    );

    // Negating the most negative angle would overflow, so it saturates.
    assign neg_x = (angle_x == DATA_MIN) ? DATA_MAX : -angle_x;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            first_reg  <= angle_y;
            second_reg <= neg_x;
        end
    end

    assign tilt_first  = first_reg;
    assign tilt_second = second_reg;

endmodule

>>> rtl/dapid_ctrl.sv
// Sequencing state machine: steps both PID lanes through one sample and runs the handshakes.
// Depends on dapid_pkg for the state and command types.
module dapid_ctrl
    import dapid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = DP_NOP;
        cmd.out_load   = 1'b0;
        in_ready       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                cmd.op     = DP_INTEG;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.op     = DP_DIFF;
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                cmd.op     = DP_PROP;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op     = DP_ACC;
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                cmd.op     = DP_DERIV;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = DP_SUM;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.op     = DP_SCALE;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // The product holds here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = DP_OUT;
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/dual_axis_pid_tilt_controller_top.sv
// Dual-axis PID tilt controller, top level.
// Each sample passes the load step, six products per axis on its single multiplier, the
// output-limit step and the output step, which waits while a result is unread; the result
// is valid after the output step, and a new sample is taken only once that step is done.
// Reset (rst_n low, asynchronous) restores register defaults and zeroes integrators and
// previous errors; the block is ready for a sample in the first cycle after reset.
module dual_axis_pid_tilt_controller_top
    import dapid_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_WIDTH-1:0]        paddr,
    input  logic [APB_WIDTH-1:0]         pwdata,
    output logic [APB_WIDTH-1:0]         prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] meas_x,
    input  logic signed [DATA_WIDTH-1:0] meas_y,
    input  logic signed [DATA_WIDTH-1:0] target_x,
    input  logic signed [DATA_WIDTH-1:0] target_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] tilt_first,
    output logic signed [DATA_WIDTH-1:0] tilt_second
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    dapid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dapid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dapid_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .meas_x      (meas_x),
        .meas_y      (meas_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .tilt_first  (tilt_first),
        .tilt_second (tilt_second)
    );

    // A new sample is never taken while the previous one is still being computed.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // The sequence runs its full length before it can finish.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##8 !in_ready)
        else $error("sample sequence ended early");

    // A result only appears at the end of a computation, never while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a computation");

endmodule
